@@ rtl/sctt_pkg.sv @@
// Shared types, constants and key tables of the scan code translator.
`timescale 1ns / 1ps
package sctt_pkg;

  localparam int NumEnt = 6;
  localparam int NumKeys = 88;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_LED  = 2'd1;
  localparam logic [1:0] KIND_CMD  = 2'd2;
  localparam logic [1:0] KIND_BOOT = 2'd3;

  localparam logic [2:0] REG_SWAP  = 3'd0;
  localparam logic [2:0] REG_OPEN  = 3'd1;
  localparam logic [2:0] REG_RAW   = 3'd2;
  localparam logic [2:0] REG_START = 3'd3;
  localparam logic [2:0] REG_STOP  = 3'd4;

  localparam logic [7:0] CMD_NUM_ON  = 8'h74;
  localparam logic [7:0] CMD_NUM_OFF = 8'h75;
  localparam logic [7:0] CMD_AKP_ON  = 8'h3D;
  localparam logic [7:0] CMD_AKP_OFF = 8'h3E;
  localparam logic [7:0] CMD_CLEAR   = 8'h63;

  localparam logic [7:0] NOCH = 8'hFF;
  localparam logic [7:0] SPEC = 8'hFE;
  localparam logic [7:0] GC = 8'h07;
  localparam logic [7:0] GL = 8'h17;
  localparam logic [7:0] GT = 8'h04;
  localparam logic [7:0] GM = 8'h80;

  localparam logic [6:0] K_BS      = 7'h0D;
  localparam logic [6:0] K_CTRL    = 7'h1C;
  localparam logic [6:0] K_LSH     = 7'h29;
  localparam logic [6:0] K_LSH_ALT = 7'h2A;
  localparam logic [6:0] K_RSH     = 7'h35;
  localparam logic [6:0] K_ALT     = 7'h37;
  localparam logic [6:0] K_CAPS    = 7'h39;
  localparam logic [6:0] K_NUM     = 7'h44;
  localparam logic [6:0] K_DEL     = 7'h52;

  localparam logic [7:0] LED_CMD = 8'hED;
  localparam logic [7:0] ACK     = 8'hFA;
  localparam logic [7:0] PFX_E0  = 8'hE0;
  localparam logic [7:0] PFX_E1  = 8'hE1;
  localparam logic [7:0] OVERRUN = 8'hFF;
  localparam logic [7:0] ESC     = 8'h1B;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } ent_t;

  typedef struct packed {
    logic [2:0]      len;
    logic [4:0][7:0] ch;
  } str_t;

  typedef struct packed {
    logic load;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic at_last;
  } sts_t;

  localparam logic [7:0] LOW_TAB [NumKeys] = '{
    8'h1B,8'h26,8'h82,8'h22,8'h27,8'h28,8'h2D,
    8'h8A,8'h5F,8'h87,8'h85,8'h29,8'h3D,8'h08,8'h09,
    8'h61,8'h7A,8'h65,8'h72,8'h74,8'h79,8'h75,8'h69,
    8'h6F,8'h70,8'hB0,8'h24,8'h0D,8'hFF,8'h71,8'h73,
    8'h64,8'h66,8'h67,8'h68,8'h6A,8'h6B,8'h6C,8'h6D,
    8'h97,8'hFD,8'hFF,8'h2A,8'h77,8'h78,8'h63,8'h76,
    8'h62,8'h6E,8'h2C,8'h3B,8'h3A,8'hFE,8'hFF,8'hFE,
    8'hFF,8'h20,8'hFF,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,
    8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,
    8'hFE,8'hFE,8'h2D,8'hFE,8'hFE,8'hFE,8'h2B,8'hFE,
    8'hFE,8'hFE,8'hFE,8'hFE,8'hFF,8'hFF,8'h3C,8'hFF,
    8'hFF};

  localparam logic [7:0] UP_TAB [NumKeys] = '{
    8'h1B,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,
    8'h37,8'h38,8'h39,8'h30,8'hF8,8'h2B,8'h08,8'hFE,
    8'h41,8'h5A,8'h45,8'h52,8'h54,8'h59,8'h55,8'h49,
    8'h4F,8'h50,8'hB1,8'h9C,8'h0D,8'hFF,8'h51,8'h53,
    8'h44,8'h46,8'h47,8'h48,8'h4A,8'h4B,8'h4C,8'h4D,
    8'h25,8'hC0,8'hFF,8'hE6,8'h57,8'h58,8'h43,8'h56,
    8'h42,8'h4E,8'h3F,8'h2E,8'h2F,8'hFE,8'hFF,8'hFE,
    8'hFF,8'h20,8'hFF,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,
    8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,
    8'hFE,8'hFE,8'h2D,8'hFE,8'hFE,8'hFE,8'h2B,8'hFE,
    8'hFE,8'hFE,8'hFE,8'hFE,8'hFF,8'hFF,8'h3E,8'hFF,
    8'hFF};

  localparam logic [7:0] GRP_TAB [NumKeys] = '{
    8'h00,8'h03,8'h07,8'h03,8'h03,8'h03,8'h07,
    8'h03,8'h03,8'h03,8'h03,8'h07,8'h03,8'h04,8'h03,
    8'h17,8'h17,8'h17,8'h17,8'h17,8'h17,8'h17,8'h17,
    8'h17,8'h17,8'h07,8'h07,8'h04,8'h80,8'h17,8'h17,
    8'h17,8'h17,8'h17,8'h17,8'h17,8'h17,8'h17,8'h03,
    8'h03,8'h07,8'h80,8'h07,8'h17,8'h17,8'h17,8'h17,
    8'h17,8'h17,8'h17,8'h03,8'h03,8'h03,8'h80,8'h03,
    8'h80,8'h07,8'h80,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h80,8'h63,8'h63,
    8'h63,8'h63,8'h00,8'h63,8'h63,8'h63,8'h00,8'h63,
    8'h63,8'h63,8'h63,8'h63,8'h00,8'h00,8'h03,8'h00,
    8'h00};

  localparam logic [7:0] AGR_TAB [13] = '{
    8'hFF,8'hFF,8'h7E,8'h23,8'h7B,8'h5B,8'h7C,8'h60,8'h5C,8'h5E,8'h40,8'h5D,8'h7D};

  localparam logic [7:0] PAD_NRM [11] = '{
    8'h48,8'h41,8'h56,8'h44,8'h37,8'h43,8'h48,8'h42,8'h55,8'h40,8'h50};
  localparam logic [7:0] PAD_SHF [11] = '{
    8'h37,8'h38,8'h39,8'h34,8'h35,8'h36,8'h31,8'h32,8'h33,8'h30,8'h2E};
  localparam logic [7:0] PAD_ALT [11] = '{
    8'h77,8'h78,8'h79,8'h74,8'h75,8'h76,8'h71,8'h72,8'h73,8'h70,8'h6E};

  function automatic logic [7:0] low_of(logic [6:0] idx, logic swap);
    if (swap && idx == K_LSH) return 8'h5C;
    if (swap && idx == K_LSH_ALT) return NOCH;
    if (idx >= 7'(NumKeys)) return NOCH;
    return LOW_TAB[idx];
  endfunction

  function automatic logic [7:0] up_of(logic [6:0] idx, logic swap);
    if (swap && idx == K_LSH) return 8'h7C;
    if (swap && idx == K_LSH_ALT) return NOCH;
    if (idx >= 7'(NumKeys)) return NOCH;
    return UP_TAB[idx];
  endfunction

  function automatic logic [7:0] grp_of(logic [6:0] idx, logic swap);
    if (swap && idx == K_LSH) return GC;
    if (swap && idx == K_LSH_ALT) return GM;
    if (idx >= 7'(NumKeys)) return 8'h00;
    return GRP_TAB[idx];
  endfunction

  function automatic str_t pad_str(logic [3:0] k, logic [1:0] sel);
    str_t s;
    s.ch = '0;
    if (sel == 2'd1) begin
      s.len = 3'd1;
      s.ch[0] = PAD_SHF[k];
    end else if (sel == 2'd2) begin
      s.len = 3'd3;
      s.ch[0] = ESC;
      s.ch[1] = 8'h3F;
      s.ch[2] = PAD_ALT[k];
    end else if (k == 4'd4) begin
      s.len = 3'd2;
      s.ch[0] = ESC;
      s.ch[1] = PAD_NRM[k];
    end else if (k == 4'd6) begin
      s.len = 3'd5;
      s.ch[0] = ESC;
      s.ch[1] = 8'h5B;
      s.ch[2] = 8'h32;
      s.ch[3] = 8'h34;
      s.ch[4] = PAD_NRM[k];
    end else begin
      s.len = 3'd3;
      s.ch[0] = ESC;
      s.ch[1] = 8'h5B;
      s.ch[2] = PAD_NRM[k];
    end
    return s;
  endfunction

endpackage

@@ rtl/sctt_in_if.sv @@
// Input channel: scan byte or command character beats.
`timescale 1ns / 1ps
interface sctt_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] code;
  logic       output_stopped;
  modport source (output valid, mode, code, output_stopped, input ready);
  modport sink (input valid, mode, code, output_stopped, output ready);
endinterface

@@ rtl/sctt_out_if.sv @@
// Result channel: translated character, LED and reboot beats.
`timescale 1ns / 1ps
interface sctt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic       last;
  modport source (output valid, kind, value, last, input ready);
  modport sink (input valid, kind, value, last, output ready);
endinterface

@@ rtl/sctt_cfg_if.sv @@
// Configuration write channel.
`timescale 1ns / 1ps
interface sctt_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/sctt_dp.sv @@
// Datapath: key state, translation logic and result buffer.
`timescale 1ns / 1ps
module sctt_dp import sctt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic       mode,
  input  logic [7:0] code,
  input  logic       output_stopped,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic [1:0] kind,
  output logic [7:0] value,
  output logic       last
);

  logic       swap, popen, raw;
  logic [7:0] start_c, stop_c;
  logic [8:0] f, f_next;
  logic       sl, sl_next, ack, ack_next, pre, pre_next;
  logic [2:0] skip, skip_next;
  ent_t       ents [NumEnt];
  ent_t       ents_next [NumEnt];
  logic [2:0] cnt, cnt_next, idx_r;

  logic [6:0] key, idx, lsh, kd;
  logic       up, ext, sh;
  logic [7:0] g, s, c, sc;
  logic [3:0] pk;
  logic [1:0] sel;
  str_t       ps;

  always_comb begin
    key = code[6:0];
    up  = code[7];
    idx = key - 7'd1;
    ext = pre;
    sh  = f[0] | f[1];
    g   = grp_of(idx, swap);
    lsh = swap ? K_LSH_ALT : K_LSH;
    s   = g & f[7:0];
    kd  = key - 7'd71 - ((key >= 7'd75) ? 7'd1 : 7'd0) - ((key >= 7'd79) ? 7'd1 : 7'd0);
    pk  = kd[3:0];
    sel = {1'b0, f[5] ^ sh};
    if (f[6]) sel = 2'd2;
    if (ext) sel = 2'd0;
    ps  = pad_str(pk, sel);
    sc  = output_stopped ? start_c : stop_c;
    if (f[8]) begin
      c = (idx < 7'd13) ? AGR_TAB[idx[3:0]] : NOCH;
    end else if (f[2]) begin
      if (g == GT) c = (idx == K_BS) ? 8'h7F : 8'h0A;
      else if (g == GC || g == GL) c = up_of(idx, swap) & 8'h1F;
      else c = NOCH;
    end else if (s != 8'h00) begin
      c = (sh ^ (s[4] | s[5])) ? up_of(idx, swap) : low_of(idx, swap);
    end else begin
      c = low_of(idx, swap);
    end
  end

  always_comb begin
    f_next    = f;
    sl_next   = sl;
    ack_next  = ack;
    pre_next  = pre;
    skip_next = skip;
    cnt_next  = '0;
    for (int i = 0; i < NumEnt; i++) ents_next[i] = '{kind: KIND_CHAR, value: 8'h00};
    if (mode) begin
      case (code)
        CMD_NUM_ON: begin
          f_next[5] = 1'b1;
          ents_next[0] = '{kind: KIND_CMD, value: LED_CMD};
          cnt_next = 3'd1;
          ack_next = 1'b1;
        end
        CMD_NUM_OFF: begin
          f_next[5] = 1'b0;
          ents_next[0] = '{kind: KIND_CMD, value: LED_CMD};
          cnt_next = 3'd1;
          ack_next = 1'b1;
        end
        CMD_AKP_ON: f_next[6] = 1'b1;
        CMD_AKP_OFF: f_next[6] = 1'b0;
        CMD_CLEAR: begin
          f_next = '0;
          ents_next[0] = '{kind: KIND_CMD, value: LED_CMD};
          cnt_next = 3'd1;
          ack_next = 1'b1;
        end
        default: ;
      endcase
    end else if (ack) begin
      ack_next = 1'b0;
      if (code == ACK) begin
        ents_next[0] = '{kind: KIND_LED, value: {5'b0, f[4], f[5], sl}};
        cnt_next = 3'd1;
      end
    end else if (skip != 3'd0) begin
      skip_next = skip - 3'd1;
    end else if (code == PFX_E0) begin
      pre_next = 1'b1;
    end else if (code == PFX_E1) begin
      skip_next = 3'd5;
    end else if (code != OVERRUN) begin
      pre_next = 1'b0;
      if (key != 7'd0 && key <= 7'd88) begin
        if (!up && idx == K_DEL && f[2] && f[3]) begin
          ents_next[0] = '{kind: KIND_BOOT, value: 8'h00};
          cnt_next = 3'd1;
        end else if (g[7]) begin
          if (up) begin
            if (idx == K_RSH) f_next[0] = 1'b0;
            else if (idx == lsh) f_next[1] = 1'b0;
            else if (idx == K_CTRL) f_next[2] = 1'b0;
            else if (idx == K_ALT) begin
              if (ext) f_next[8] = 1'b0;
              else f_next[3] = 1'b0;
            end
          end else begin
            if (idx == lsh) f_next[1] = 1'b1;
            else if (idx == K_RSH) f_next[0] = 1'b1;
            else if (idx == K_CTRL) f_next[2] = 1'b1;
            else if (idx == K_ALT) begin
              if (ext) f_next[8] = 1'b1;
              else f_next[3] = 1'b1;
            end else if (idx == K_CAPS || idx == K_NUM) begin
              if (idx == K_CAPS) f_next[4] = ~f[4];
              else f_next[5] = ~f[5];
              ents_next[0] = '{kind: KIND_CMD, value: LED_CMD};
              cnt_next = 3'd1;
              ack_next = 1'b1;
            end
          end
        end else if (!up && popen && c != NOCH) begin
          if (c != SPEC) begin
            ents_next[0] = '{kind: KIND_CHAR, value: {c[7] | f[3], c[6:0]}};
            cnt_next = 3'd1;
          end else if (key == 7'd15) begin
            ents_next[0] = '{kind: KIND_CHAR, value: ESC};
            ents_next[1] = '{kind: KIND_CHAR, value: 8'h5B};
            ents_next[2] = '{kind: KIND_CHAR, value: 8'h5A};
            cnt_next = 3'd3;
          end else if (key == 7'd53) begin
            ents_next[0] = '{kind: KIND_CHAR,
                             value: ext ? 8'h2F : (sh ? 8'h15 : 8'h21)};
            cnt_next = 3'd1;
          end else if (key == 7'd55) begin
            if (!ext) begin
              ents_next[0] = '{kind: KIND_CHAR, value: 8'h2A};
              cnt_next = 3'd1;
            end
          end else if (key >= 7'd59 && key <= 7'd68) begin
            ents_next[0] = '{kind: KIND_CHAR, value: ESC};
            ents_next[1] = '{kind: KIND_CHAR, value: 8'h5B};
            ents_next[2] = '{kind: KIND_CHAR,
                             value: (key == 7'd68) ? 8'h30 : {1'b0, key - 7'd58} + 8'h30};
            ents_next[3] = '{kind: KIND_CHAR, value: f[3] ? 8'h79 : 8'h78};
            cnt_next = 3'd4;
          end else if (key == 7'd70) begin
            if (!raw) begin
              sl_next  = !output_stopped;
              ack_next = 1'b1;
              if (sc != 8'h00 && sc != 8'hFF) begin
                ents_next[0] = '{kind: KIND_CHAR, value: sc};
                ents_next[1] = '{kind: KIND_CMD, value: LED_CMD};
                cnt_next = 3'd2;
              end else begin
                ents_next[0] = '{kind: KIND_CMD, value: LED_CMD};
                cnt_next = 3'd1;
              end
            end
          end else if (key >= 7'd71 && key <= 7'd83 && key != 7'd74 && key != 7'd78) begin
            for (int i = 0; i < 5; i++) ents_next[i] = '{kind: KIND_CHAR, value: ps.ch[i]};
            cnt_next = ps.len;
          end
        end
      end
    end
  end

  assign sts.empty   = (cnt_next == 3'd0);
  assign sts.at_last = (idx_r == cnt - 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      swap    <= 1'b0;
      popen   <= 1'b1;
      raw     <= 1'b0;
      start_c <= 8'd17;
      stop_c  <= 8'd19;
      f       <= '0;
      sl      <= 1'b0;
      ack     <= 1'b0;
      pre     <= 1'b0;
      skip    <= '0;
      cnt     <= '0;
      idx_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SWAP:  swap    <= cfg_data[0];
          REG_OPEN:  popen   <= cfg_data[0];
          REG_RAW:   raw     <= cfg_data[0];
          REG_START: start_c <= cfg_data;
          REG_STOP:  stop_c  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        f     <= f_next;
        sl    <= sl_next;
        ack   <= ack_next;
        pre   <= pre_next;
        skip  <= skip_next;
        cnt   <= cnt_next;
        idx_r <= '0;
      end else if (cmd.advance) begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < NumEnt; i++) ents[i] <= ents_next[i];
    end
  end

  assign kind  = ents[idx_r].kind;
  assign value = ents[idx_r].value;
  assign last  = sts.at_last;

endmodule

@@ rtl/sctt_ctrl.sv @@
// Controller: accepts one beat, then sends its results one per cycle while the output is ready.
`timescale 1ns / 1ps
module sctt_ctrl import sctt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE = 2'b01,
    SEND = 2'b10
  } state_t;

  state_t state, state_next;

  assign in_ready    = (state == IDLE);
  assign out_valid   = (state == SEND);
  assign cmd.load    = in_valid && in_ready;
  assign cmd.advance = out_valid && out_ready && !sts.at_last;

  always_comb begin
    state_next = state;
    unique case (state)
      IDLE: if (cmd.load && !sts.empty) state_next = SEND;
      SEND: if (out_ready && sts.at_last) state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= IDLE;
    else state <= state_next;
  end

endmodule

@@ rtl/scan_code_to_char_translator_top.sv @@
// Top level of the set-1 scan code to character translator.
// The first result is presented in the cycle after the input beat is accepted.
// Each input beat yields n results (0 to 5), sent one per cycle while result.ready is high,
// from the result buffer; the controller takes no new beat until the last is sent.
// Reset: synchronous, clears key state and restores register defaults.
`timescale 1ns / 1ps
module scan_code_to_char_translator_top import sctt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  sctt_in_if.sink    scan,
  sctt_out_if.source result,
  sctt_cfg_if.sink   cfg
);

  cmd_t cmd;
  sts_t sts;

  assign cfg.ready = 1'b1;

  sctt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (scan.valid),
    .in_ready  (scan.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sctt_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .mode           (scan.mode),
    .code           (scan.code),
    .output_stopped (scan.output_stopped),
    .cfg_we         (cfg.valid && cfg.ready),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .kind           (result.kind),
    .value          (result.value),
    .last           (result.last)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !scan.ready) else $error("input taken while results pending");

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready && !result.last |=> result.valid)
    else $error("result burst broken before last beat");

  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready && result.last |=> scan.ready)
    else $error("input not reopened after last beat");

  a_load_when_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !result.valid) else $error("load during send");

endmodule
